FILE: design/incremental_pid_with_lowpass_core_defines.svh
// Assertion macros for the incremental PID core.
// Used by the top level only; defining NO_ASSERTIONS leaves the macros empty.
`ifndef INCREMENTAL_PID_WITH_LOWPASS_CORE_DEFINES_SVH
`define INCREMENTAL_PID_WITH_LOWPASS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on aclk, off during reset
`define IPID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPID_ASSERT_IMP(lbl, ante, cons, msg)
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/ipid_pkg.sv
// Shared widths, register indexes, state and command types for the PID core.
// No dependencies.
`timescale 1ns / 1ps

package ipid_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_W      = 16;
    localparam int DRIVE_W     = 32;
    localparam int LIMIT_W     = 31;
    localparam int WEIGHT_W    = 16;

    localparam int ERR_W       = SAMPLE_BITS + 1;   // setpoint - measured
    localparam int D1_W        = ERR_W + 1;         // e - e1
    localparam int D2_W        = ERR_W + 2;         // e - 2*e1 + e2
    localparam int PROD_MAX_W  = D2_W + GAIN_W;
    // headroom for drive plus three gain products
    localparam int ACC_W       = ((PROD_MAX_W > DRIVE_W) ? PROD_MAX_W : DRIVE_W) + 3;
    localparam int MUL_A_W     = ACC_W + 1;         // also holds acc - drive
    localparam int MUL_B_W     = WEIGHT_W + 1;      // gain or unsigned weight
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_KP        = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_KI        = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_KD        = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_LIMIT = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] CFG_LP_ON     = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] CFG_LP_WEIGHT = CFG_ADDR_W'(5);

    localparam logic [WEIGHT_W-1:0] LP_WEIGHT_RESET = WEIGHT_W'(19661);  // 0.3

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ADD_D,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_CLAMP
    } state_t;

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D,
        MSEL_MIX
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_MIX
    } acc_op_t;

    typedef struct packed {
        logic     load;     // latch a new item, shift error history
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     commit;   // clamp, update drive state, present result
    } ipid_cmd_t;

endpackage

FILE: design/incremental_pid_with_lowpass_core.sv
// Incremental PID core with optional low-pass on the drive.
// Steps: accept, P, I and D products, add, mix product and add (low-pass on), clamp.
// One item at a time, taken only while idle; the clamp waits on m_ready. The single
// shared multiplier takes three gain products (and one mix product) in turn.
// Reset (aresetn, synchronous, low): history and drive cleared, gains and
// limit zero, low-pass off with weight 0.3; no clearing pass.
`timescale 1ns / 1ps
`include "incremental_pid_with_lowpass_core_defines.svh"

module incremental_pid_with_lowpass_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [ipid_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [ipid_pkg::SAMPLE_BITS-1:0] s_setpoint,
    input  logic signed [ipid_pkg::SAMPLE_BITS-1:0] s_measured,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [ipid_pkg::DRIVE_W-1:0]     m_drive
);

    ipid_pkg::ipid_cmd_t cmd;
    logic                lowpass_on;

    ipid_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .lowpass_on (lowpass_on),
        .cmd        (cmd)
    );

    ipid_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_setpoint (s_setpoint),
        .s_measured (s_measured),
        .cmd        (cmd),
        .lowpass_on (lowpass_on),
        .m_drive    (m_drive)
    );

    `IPID_ASSERT_NEXT(a_one_item_in_flight, s_valid && s_ready, !s_ready, "item accepted while busy")
    `IPID_ASSERT_IMP(a_commit_slot_free, cmd.commit, !m_valid || m_ready, "result overwritten")
    `IPID_ASSERT_IMP(a_valid_from_commit, $rose(m_valid), $past(cmd.commit), "result without commit")
    `IPID_ASSERT_IMP(a_no_load_at_commit, s_valid && s_ready, !cmd.commit, "accept during commit")

endmodule

FILE: design/ipid_ctrl.sv
// Sequencer for the PID core: steps the shared multiplier and owns the
// input ready and result valid. Depends on ipid_pkg.
`timescale 1ns / 1ps

module ipid_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              lowpass_on,
    output ipid_pkg::ipid_cmd_t cmd
);

    ipid_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ipid_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ipid_pkg::ST_IDLE: begin
                if (s_valid) state_next = ipid_pkg::ST_MUL_P;
            end
            ipid_pkg::ST_MUL_P:   state_next = ipid_pkg::ST_MUL_I;
            ipid_pkg::ST_MUL_I:   state_next = ipid_pkg::ST_MUL_D;
            ipid_pkg::ST_MUL_D:   state_next = ipid_pkg::ST_ADD_D;
            ipid_pkg::ST_ADD_D: begin
                state_next = lowpass_on ? ipid_pkg::ST_MIX_MUL : ipid_pkg::ST_CLAMP;
            end
            ipid_pkg::ST_MIX_MUL: state_next = ipid_pkg::ST_MIX_ADD;
            ipid_pkg::ST_MIX_ADD: state_next = ipid_pkg::ST_CLAMP;
            ipid_pkg::ST_CLAMP: begin
                if (out_free) state_next = ipid_pkg::ST_IDLE;
            end
            default:              state_next = ipid_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_sel = ipid_pkg::MSEL_MIX;
        cmd.acc_op  = ipid_pkg::ACC_HOLD;
        cmd.commit  = 1'b0;
        case (state_reg)
            ipid_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ipid_pkg::ST_MUL_P: begin
                cmd.mul_sel = ipid_pkg::MSEL_P;
            end
            ipid_pkg::ST_MUL_I: begin
                cmd.mul_sel = ipid_pkg::MSEL_I;
                cmd.acc_op  = ipid_pkg::ACC_LOAD;
            end
            ipid_pkg::ST_MUL_D: begin
                cmd.mul_sel = ipid_pkg::MSEL_D;
                cmd.acc_op  = ipid_pkg::ACC_ADD;
            end
            ipid_pkg::ST_ADD_D: begin
                cmd.acc_op  = ipid_pkg::ACC_ADD;
            end
            ipid_pkg::ST_MIX_MUL: begin
                cmd.mul_sel = ipid_pkg::MSEL_MIX;
            end
            ipid_pkg::ST_MIX_ADD: begin
                cmd.acc_op  = ipid_pkg::ACC_MIX;
            end
            ipid_pkg::ST_CLAMP: begin
                cmd.commit  = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: design/ipid_dp.sv
// Datapath of the PID core: config registers, error history, shared
// multiplier, accumulator, low-pass mix and clamp. Depends on ipid_pkg.
`timescale 1ns / 1ps

module ipid_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [ipid_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic signed [ipid_pkg::SAMPLE_BITS-1:0] s_setpoint,
    input  logic signed [ipid_pkg::SAMPLE_BITS-1:0] s_measured,
    input  ipid_pkg::ipid_cmd_t                   cmd,
    output logic                                  lowpass_on,
    output logic signed [ipid_pkg::DRIVE_W-1:0]   m_drive
);

    logic signed [ipid_pkg::GAIN_W-1:0]   kp_reg, ki_reg, kd_reg;
    logic        [ipid_pkg::LIMIT_W-1:0]  limit_reg;
    logic                                 lp_on_reg;
    logic        [ipid_pkg::WEIGHT_W-1:0] weight_reg;

    logic signed [ipid_pkg::ERR_W-1:0]    err_prev_reg, err_prev2_reg;
    logic signed [ipid_pkg::DRIVE_W-1:0]  drive_acc_reg;

    logic signed [ipid_pkg::ERR_W-1:0]    err_reg;
    logic signed [ipid_pkg::D1_W-1:0]     d1_reg;
    logic signed [ipid_pkg::D2_W-1:0]     d2_reg;
    logic signed [ipid_pkg::ERR_W-1:0]    err_next;
    logic signed [ipid_pkg::D1_W-1:0]     d1_next;
    logic signed [ipid_pkg::D2_W-1:0]     d2_next;

    logic signed [ipid_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [ipid_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [ipid_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ipid_pkg::PROD_W:0]     prod_neg;

    logic signed [ipid_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ipid_pkg::ACC_W-1:0]    lim_pos, lim_neg, clamped;
    logic signed [ipid_pkg::DRIVE_W-1:0]  drive_next;
    logic signed [ipid_pkg::DRIVE_W-1:0]  m_drive_reg;

    // configuration: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            limit_reg  <= '0;
            lp_on_reg  <= 1'b0;
            weight_reg <= ipid_pkg::LP_WEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ipid_pkg::CFG_KP:        kp_reg     <= cfg_wdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_KI:        ki_reg     <= cfg_wdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_KD:        kd_reg     <= cfg_wdata[ipid_pkg::GAIN_W-1:0];
                ipid_pkg::CFG_OUT_LIMIT: limit_reg  <= cfg_wdata[ipid_pkg::LIMIT_W-1:0];
                ipid_pkg::CFG_LP_ON:     lp_on_reg  <= cfg_wdata[0];
                ipid_pkg::CFG_LP_WEIGHT: weight_reg <= cfg_wdata[ipid_pkg::WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign lowpass_on = lp_on_reg;

    // error and its differences, taken when the item is accepted
    assign err_next = ipid_pkg::ERR_W'(s_setpoint) - ipid_pkg::ERR_W'(s_measured);
    assign d1_next  = ipid_pkg::D1_W'(err_next) - ipid_pkg::D1_W'(err_prev_reg);
    assign d2_next  = ipid_pkg::D2_W'(err_next) - (ipid_pkg::D2_W'(err_prev_reg) <<< 1)
                    + ipid_pkg::D2_W'(err_prev2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_prev_reg  <= '0;
            err_prev2_reg <= '0;
            drive_acc_reg <= '0;
        end else begin
            if (cmd.load) begin
                err_prev_reg  <= err_next;
                err_prev2_reg <= err_prev_reg;
            end
            if (cmd.commit) begin
                drive_acc_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg <= err_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            ipid_pkg::MSEL_P: begin
                mul_a = ipid_pkg::MUL_A_W'(d1_reg);
                mul_b = ipid_pkg::MUL_B_W'(kp_reg);
            end
            ipid_pkg::MSEL_I: begin
                mul_a = ipid_pkg::MUL_A_W'(err_reg);
                mul_b = ipid_pkg::MUL_B_W'(ki_reg);
            end
            ipid_pkg::MSEL_D: begin
                mul_a = ipid_pkg::MUL_A_W'(d2_reg);
                mul_b = ipid_pkg::MUL_B_W'(kd_reg);
            end
            ipid_pkg::MSEL_MIX: begin
                // (sum - prev) * f; mixed = sum + floor(-(that) / 2^16)
                mul_a = ipid_pkg::MUL_A_W'(acc_reg) - ipid_pkg::MUL_A_W'(drive_acc_reg);
                mul_b = signed'({1'b0, weight_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod_neg = -(ipid_pkg::PROD_W + 1)'(prod_reg);

    always_comb begin
        case (cmd.acc_op)
            ipid_pkg::ACC_HOLD: acc_next = acc_reg;
            ipid_pkg::ACC_LOAD: acc_next = ipid_pkg::ACC_W'(drive_acc_reg)
                                         + ipid_pkg::ACC_W'(prod_reg);
            ipid_pkg::ACC_ADD:  acc_next = acc_reg + ipid_pkg::ACC_W'(prod_reg);
            ipid_pkg::ACC_MIX:  acc_next = acc_reg
                                         + ipid_pkg::ACC_W'(prod_neg >>> ipid_pkg::WEIGHT_W);
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // symmetric clamp; a zero limit forces zero
    assign lim_pos = signed'(ipid_pkg::ACC_W'(limit_reg));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (acc_reg <= lim_neg) begin
            clamped = lim_neg;
        end else if (acc_reg >= lim_pos) begin
            clamped = lim_pos;
        end else begin
            clamped = acc_reg;
        end
    end

    assign drive_next = ipid_pkg::DRIVE_W'(clamped);

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_drive_reg <= drive_next;
        end
    end

    assign m_drive = m_drive_reg;

endmodule
